FILE: hw/rtl/mtf_pkg.sv
// shared types and codes for the minimum-tracking queue
// no dependencies; imported by mtf_ctrl, mtf_dpath and min_tracking_fifo_core
package mtf_pkg;

   localparam int unsigned DEF_QUEUE_DEPTH = 1024;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned TOTAL_W = 11;

   // request command codes (6 and 7 mean nothing and answer error)
   typedef enum logic [2:0] {
      CMD_PUSH  = 3'd0,
      CMD_POP   = 3'd1,
      CMD_FRONT = 3'd2,
      CMD_SIZE  = 3'd3,
      CMD_CLEAR = 3'd4,
      CMD_MIN   = 3'd5
   } cmd_type;

   // response kinds
   typedef enum logic [1:0] {
      KIND_OK    = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_COUNT = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic scan_step;
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic scan_needed;
      logic scan_done;
   } status_type;

endpackage

FILE: hw/rtl/mtf_ctrl.sv
// controller state machine for the minimum-tracking queue
// depends on mtf_pkg
module mtf_ctrl
   import mtf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = status.scan_needed ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
         end
         ST_SCAN: begin
            ctrl.scan_step = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: hw/rtl/mtf_dpath.sv
// datapath of the minimum-tracking queue: entry memory, indices, count,
// running minimum, rescan walker and response registers; depends on mtf_pkg
module mtf_dpath
   import mtf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_type                  ctrl,
   output status_type                status,
   input  logic [2:0]                req_command,
   input  logic signed [DATA_W-1:0]  req_push_value,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_response_kind,
   output logic signed [DATA_W-1:0]  rsp_result_value,
   output logic [TOTAL_W-1:0]        rsp_entry_total
);

   localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   // entry memory, one write and one registered read port
   logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;

   // request latch
   cmd_type                  cmd_ff;
   logic signed [DATA_W-1:0] val_ff;

   // queue state
   logic [ADDR_W-1:0]        head_ff, head_in;
   logic [ADDR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] min_ff, min_in;

   // rescan walker
   logic [ADDR_W-1:0]        scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]         scan_left_ff, scan_left_in;
   logic                     scan_vld_ff, scan_vld_in;
   logic                     scan_first_ff, scan_first_in;

   // response registers
   logic                     rsp_valid_ff;
   kind_type                 kind_ff, kind_in;
   logic signed [DATA_W-1:0] result_ff, result_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;

   logic                     empty;
   logic                     full;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
      next_slot = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
   endfunction

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == FULL_CNT);
   assign rd_addr    = ctrl.scan_step ? scan_addr_ff : head_ff;
   assign wr_en      = ctrl.exec && (cmd_ff == CMD_PUSH) && !full;

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= val_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // request latch
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= cmd_type'(req_command);
         val_ff <= req_push_value;
      end
   end

   // command execution and rescan
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      min_in        = min_ff;
      scan_addr_in  = scan_addr_ff;
      scan_left_in  = scan_left_ff;
      scan_vld_in   = 1'b0;
      scan_first_in = scan_first_ff;
      kind_in       = KIND_ERROR;
      result_in     = '0;
      total_in      = '0;
      status.scan_needed = 1'b0;
      status.scan_done   = (scan_left_ff == '0) && !scan_vld_ff;

      if (ctrl.exec) begin
         case (cmd_ff)
            CMD_PUSH: begin
               if (!full) begin
                  tail_in  = next_slot(tail_ff);
                  count_in = count_ff + 1'b1;
                  if (empty || (val_ff < min_ff)) begin
                     min_in = val_ff;
                  end
                  kind_in = KIND_OK;
               end
            end
            CMD_POP: begin
               if (!empty) begin
                  head_in       = next_slot(head_ff);
                  count_in      = count_ff - 1'b1;
                  kind_in       = KIND_VALUE;
                  result_in     = rd_data_ff;
                  scan_addr_in  = next_slot(head_ff);
                  scan_left_in  = count_ff - 1'b1;
                  scan_first_in = 1'b1;
                  status.scan_needed = (count_ff != CNT_W'(1)) && (rd_data_ff == min_ff);
               end
            end
            CMD_FRONT: begin
               if (!empty) begin
                  kind_in   = KIND_VALUE;
                  result_in = rd_data_ff;
               end
            end
            CMD_SIZE: begin
               kind_in  = KIND_COUNT;
               total_in = TOTAL_W'(count_ff);
            end
            CMD_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
               kind_in  = KIND_OK;
            end
            CMD_MIN: begin
               if (!empty) begin
                  kind_in   = KIND_VALUE;
                  result_in = min_ff;
               end
            end
            default: begin
               kind_in = KIND_ERROR;
            end
         endcase
      end

      // rescan: issue one read a cycle, fold the previous read into the minimum
      if (ctrl.scan_step) begin
         if (scan_left_ff != '0) begin
            scan_addr_in = next_slot(scan_addr_ff);
            scan_left_in = scan_left_ff - 1'b1;
            scan_vld_in  = 1'b1;
         end
         if (scan_vld_ff) begin
            scan_first_in = 1'b0;
            if (scan_first_ff || (rd_data_ff < min_ff)) begin
               min_in = rd_data_ff;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         min_ff       <= '0;
         scan_left_ff <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         scan_left_ff <= scan_left_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= ctrl.exec;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      scan_first_ff <= scan_first_in;
      kind_ff       <= kind_in;
      result_ff     <= result_in;
      total_ff      <= total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_response_kind = kind_ff;
   assign rsp_result_value  = result_ff;
   assign rsp_entry_total   = total_ff;

endmodule

FILE: hw/rtl/min_tracking_fifo_core.sv
// top level of the minimum-tracking queue
// depends on mtf_pkg, mtf_ctrl and mtf_dpath

// A request is taken at a clock edge where start is high and busy is low. Its
// response is on the rsp_ ports for exactly one cycle, marked by rsp_valid, and
// is registered from the execute state that follows the request; the receiver
// cannot stall it. busy is high in the execute state after a request is taken,
// so a new request cannot be taken before the last one has executed. A pop that
// removes an entry equal to the current minimum keeps busy high in a rescan state
// while the remaining entries are read back one per cycle through the single
// read port of the entry memory to rebuild the minimum; its response is still
// registered from the execute state.
// There is no clearing pass after reset: the first request can be taken at once.
module min_tracking_fifo_core
   import mtf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_command,
   input  logic signed [DATA_W-1:0]  req_push_value,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_response_kind,
   output logic signed [DATA_W-1:0]  rsp_result_value,
   output logic [TOTAL_W-1:0]        rsp_entry_total
);

   ctrl_type   ctrl;
   status_type status;

   // controller
   mtf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // datapath
   mtf_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_command       (req_command),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_response_kind (rsp_response_kind),
      .rsp_result_value  (rsp_result_value),
      .rsp_entry_total   (rsp_entry_total)
   );

`ifndef SYNTHESIS
   // a taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // a response follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");

   // responses never come in consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses back to back");

   // the rescan only runs while busy
   assert property (@(posedge clock) disable iff (reset)
      ctrl.scan_step |-> busy)
      else $error("rescan step while idle");
`endif

endmodule

FILE: tb/mtf_scoreboard.sv
`timescale 1ns / 1ps
// scoreboard for min_tracking_fifo_core: watches the request and response ports,
// predicts every response and compares it; depends on mtf_pkg only
module mtf_scoreboard
   import mtf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [2:0]               req_command,
   input  logic signed [DATA_W-1:0] req_push_value,
   input  logic                     rsp_valid,
   input  logic [1:0]               rsp_response_kind,
   input  logic signed [DATA_W-1:0] rsp_result_value,
   input  logic [TOTAL_W-1:0]       rsp_entry_total,
   output int                       fail_count,
   output int                       outstanding,
   output int                       checked_total,
   output int                       rescan_total
);

   typedef struct packed {
      kind_type                 kind;
      logic signed [DATA_W-1:0] value;
      logic [TOTAL_W-1:0]       total;
   } answer_type;

   // mirror of the queue contents and its bookkeeping
   logic signed [DATA_W-1:0] entry_mirror [QUEUE_DEPTH];
   int unsigned              head_slot = 0;
   int unsigned              tail_slot = 0;
   int unsigned              queued = 0;
   logic signed [DATA_W-1:0] running_min = '0;

   answer_type expected_answers [$];
   answer_type want;
   int         fails = 0;
   int         checked = 0;
   int         rescans = 0;

   // apply one request to the mirror and queue up the response it must give
   function automatic void predict_answer(input logic [2:0] cmd,
                                          input logic signed [DATA_W-1:0] value);
      answer_type               ans;
      logic signed [DATA_W-1:0] popped;
      int unsigned              slot;
      ans.kind  = KIND_ERROR;
      ans.value = '0;
      ans.total = '0;
      case (cmd)
         CMD_PUSH: begin
            if (queued < QUEUE_DEPTH) begin
               entry_mirror[tail_slot] = value;
               tail_slot = (tail_slot + 1 == QUEUE_DEPTH) ? 0 : tail_slot + 1;
               if (queued == 0 || value < running_min)
                  running_min = value;
               queued++;
               ans.kind = KIND_OK;
            end
         end
         CMD_POP: begin
            if (queued != 0) begin
               popped = entry_mirror[head_slot];
               head_slot = (head_slot + 1 == QUEUE_DEPTH) ? 0 : head_slot + 1;
               queued--;
               // removing the minimum forces a rebuild over what is left
               if (queued != 0 && popped == running_min) begin
                  running_min = entry_mirror[head_slot];
                  slot = head_slot;
                  repeat (queued) begin
                     if (entry_mirror[slot] < running_min)
                        running_min = entry_mirror[slot];
                     slot = (slot + 1 == QUEUE_DEPTH) ? 0 : slot + 1;
                  end
                  rescans++;
               end
               ans.kind  = KIND_VALUE;
               ans.value = popped;
            end
         end
         CMD_FRONT: begin
            if (queued != 0) begin
               ans.kind  = KIND_VALUE;
               ans.value = entry_mirror[head_slot];
            end
         end
         CMD_SIZE: begin
            ans.kind  = KIND_COUNT;
            ans.total = TOTAL_W'(queued);
         end
         CMD_CLEAR: begin
            // contents stay, only the pointers and count go back to zero
            head_slot = 0;
            tail_slot = 0;
            queued    = 0;
            ans.kind  = KIND_OK;
         end
         CMD_MIN: begin
            if (queued != 0) begin
               ans.kind  = KIND_VALUE;
               ans.value = running_min;
            end
         end
         default: begin
            ans.kind = KIND_ERROR;
         end
      endcase
      expected_answers.insert(expected_answers.size(), ans);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_answers.delete();
         head_slot   = 0;
         tail_slot   = 0;
         queued      = 0;
         running_min = '0;
      end else begin
         // responses are matched before this edge's request is predicted
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               fails++;
               $display("%0t: response with nothing expected, got kind %0d value %0d total %0d",
                        $time, rsp_response_kind, rsp_result_value, rsp_entry_total);
            end else begin
               want = expected_answers.pop_front();
               checked++;
               if (rsp_response_kind !== want.kind) begin
                  fails++;
                  $display("%0t: response kind expected %0d got %0d",
                           $time, want.kind, rsp_response_kind);
               end
               if (rsp_result_value !== want.value) begin
                  fails++;
                  $display("%0t: result value expected %0d got %0d",
                           $time, want.value, rsp_result_value);
               end
               if (rsp_entry_total !== want.total) begin
                  fails++;
                  $display("%0t: entry total expected %0d got %0d",
                           $time, want.total, rsp_entry_total);
               end
            end
         end
         if (start && !busy)
            predict_answer(req_command, req_push_value);
      end
      fail_count    <= fails;
      outstanding   <= expected_answers.size();
      checked_total <= checked;
      rescan_total  <= rescans;
   end

endmodule

FILE: tb/tb_min_tracking_fifo_core.sv
`timescale 1ns / 1ps
// top of the min_tracking_fifo_core testbench: clock, reset, request stimulus, verdict
// depends on mtf_pkg, min_tracking_fifo_core and mtf_scoreboard
module tb_min_tracking_fifo_core;
   import mtf_pkg::*;

   localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;
   localparam int          RANDOM_REQUESTS = 320;
   // codes with no meaning, the block must answer error
   localparam logic [2:0]  CMD_UNUSED_LO = 3'd6;
   localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [2:0]               req_command = CMD_PUSH;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_response_kind;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [TOTAL_W-1:0]       rsp_entry_total;

   int fail_count;
   int outstanding;
   int checked_total;
   int rescan_total;
   int sent_by_cmd [8];
   bit back_to_back = 1'b0;
   int push_bias = 50;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   min_tracking_fifo_core #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_response_kind (rsp_response_kind),
      .rsp_result_value  (rsp_result_value),
      .rsp_entry_total   (rsp_entry_total)
   );

   mtf_scoreboard #(.QUEUE_DEPTH(DEPTH)) u_scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_response_kind (rsp_response_kind),
      .rsp_result_value  (rsp_result_value),
      .rsp_entry_total   (rsp_entry_total),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .checked_total     (checked_total),
      .rescan_total      (rescan_total)
   );

   // present one request, after an optional gap, and hold it until taken
   task automatic send_request(input logic [2:0] cmd, input logic signed [DATA_W-1:0] value);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_push_value <= value;
      sent_by_cmd[cmd]++;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and wait for every expected response, then a few spare cycles
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   // mostly small values so that duplicates of the minimum are common
   function automatic logic signed [DATA_W-1:0] pick_value();
      int small_val;
      small_val = $urandom_range(0, 16);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return small_val - 8;
         5: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_command(input int bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return CMD_CLEAR;
      if (r < 6) return ($urandom_range(0, 1) != 0) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      if (r < 14) return CMD_SIZE;
      if (r < 24) return CMD_FRONT;
      if (r < 34) return CMD_MIN;
      return ($urandom_range(0, 99) < bias) ? CMD_PUSH : CMD_POP;
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-queue errors, unused codes, extremes and minimum rebuilds
      send_request(CMD_POP, $urandom);
      send_request(CMD_FRONT, $urandom);
      send_request(CMD_MIN, $urandom);
      send_request(CMD_SIZE, $urandom);
      send_request(CMD_UNUSED_LO, $urandom);
      send_request(CMD_UNUSED_HI, $urandom);
      send_request(CMD_CLEAR, $urandom);
      send_request(CMD_PUSH, 32'sh7fff_ffff);
      send_request(CMD_PUSH, 32'sh8000_0000);
      send_request(CMD_PUSH, -32'sd1);
      send_request(CMD_PUSH, 32'sh0);
      send_request(CMD_MIN, $urandom);
      send_request(CMD_FRONT, $urandom);
      send_request(CMD_SIZE, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_MIN, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_MIN, $urandom);
      send_request(CMD_PUSH, 32'sd5);
      send_request(CMD_PUSH, 32'sd5);
      send_request(CMD_POP, $urandom);
      send_request(CMD_MIN, $urandom);
      send_request(CMD_CLEAR, $urandom);
      wait_for_drain();

      // fill to the brim, wrapping the tail pointer, knock on the full queue, then pop and refill
      send_request(CMD_CLEAR, $urandom);
      for (int i = 0; i < DEPTH; i++) begin
         back_to_back = (i < DEPTH / 2);
         send_request(CMD_PUSH, pick_value());
      end
      back_to_back = 1'b0;
      send_request(CMD_PUSH, pick_value());
      send_request(CMD_PUSH, pick_value());
      send_request(CMD_SIZE, $urandom);
      send_request(CMD_MIN, $urandom);
      send_request(CMD_FRONT, $urandom);
      for (int i = 0; i < 40; i++) begin
         send_request(CMD_POP, $urandom);
         send_request(CMD_PUSH, pick_value());
         send_request(CMD_PUSH, pick_value());
      end
      send_request(CMD_MIN, $urandom);
      send_request(CMD_CLEAR, $urandom);
      wait_for_drain();

      // random mix with drifting fill level and bursts without gaps
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 100 == 0)
            push_bias = 25 * $urandom_range(1, 3);
         if (i % 50 == 0)
            back_to_back = ($urandom_range(0, 3) == 0);
         send_request(pick_command(push_bias), pick_value());
      end
      back_to_back = 1'b0;
      wait_for_drain();

      $display("covered %0d push, %0d pop, %0d front, %0d size, %0d clear, %0d min, %0d unused",
               sent_by_cmd[CMD_PUSH], sent_by_cmd[CMD_POP], sent_by_cmd[CMD_FRONT],
               sent_by_cmd[CMD_SIZE], sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_MIN],
               sent_by_cmd[CMD_UNUSED_LO] + sent_by_cmd[CMD_UNUSED_HI]);
      $display("%0d responses checked, %0d minimum rebuilds, queue filled to %0d entries",
               checked_total, rescan_total, DEPTH);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
